### hdl/uvsr_pkg.sv
`timescale 1ns / 1ps
// uvsr_pkg: shared widths and constants for the uv extent snap rescale unit.
// No dependencies.
package uvsr_pkg;

  localparam int COORD_W     = 32;
  localparam int IN_TDATA_W  = 2 * COORD_W;
  localparam int OUT_TDATA_W = 2 * COORD_W;
  localparam int OUT_TUSER_W = 3;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic overflowed;
    logic flat_v;
    logic flat_u;
  } out_flags_t;

endpackage

### hdl/uv_extent_snap_rescale_unit.sv
`timescale 1ns / 1ps
// uv_extent_snap_rescale_unit: collects (u, v) pairs, snaps each axis extent to
// whole units and re-emits every pair rescaled about its axis center.
// Depends on uvsr_pkg and uvsr_ram.
//
//   channel | direction | payload
//   in_     | slave     | tdata {v_in, u_in}, tlast last_in
//   out_    | master    | tdata {v_out, u_out}, tlast last_out,
//           |           | tuser {overflowed, flat_v, flat_u}
//
// Loading takes one request per cycle; a pair beyond MAX_PAIRS is dropped.
// After the last pair, S_PREP and then S_DIV compute both scales (one
// restoring divider per axis, one quotient bit a cycle).
// Each stored pair then passes S_RD (RAM read), S_MUL (multiply), S_FIN (round)
// and S_OUT (held by any output stall); no input is taken until the whole set is out.
// Reset (synchronous, rst_n low) clears the pair count, drop flag and min/max.
module uv_extent_snap_rescale_unit #(
  parameter int MAX_PAIRS = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [uvsr_pkg::IN_TDATA_W-1:0]      in_tdata,   // u_in, v_in
  input  logic                                 in_tlast,   // last_in
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [uvsr_pkg::OUT_TDATA_W-1:0]     out_tdata,  // u_out, v_out
  output logic                                 out_tlast,  // last_out
  output logic [uvsr_pkg::OUT_TUSER_W-1:0]     out_tuser   // flat_u, flat_v, overflowed
);

  localparam int XW     = uvsr_pkg::COORD_W;
  localparam int CW     = $clog2(MAX_PAIRS + 1);
  localparam int ADDR_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int EW     = XW + 1;
  localparam int SW     = FRAC_BITS + 2;
  localparam int NUMW   = FRAC_BITS + EW + 1;
  localparam int NW     = EW - FRAC_BITS + 1;
  localparam int STW    = $clog2(SW + 1);
  localparam int D2W    = XW + 2;
  localparam int PW     = D2W + SW + 1;
  localparam int ACCW   = PW + 1;

  localparam logic signed [ACCW-1:0] SAT_HI = ACCW'(64'sd2147483647);
  localparam logic signed [ACCW-1:0] SAT_LO = ACCW'(-64'sd2147483648);

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]   state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic          drop_r, drop_nxt;
  uvsr_pkg::coord_t umin_r, umin_nxt, umax_r, umax_nxt;
  uvsr_pkg::coord_t vmin_r, vmin_nxt, vmax_r, vmax_nxt;
  logic [STW-1:0] step_r, step_nxt;

  logic                 flat_u_r, flat_v_r;
  logic signed [EW-1:0] c2u_r, c2v_r;
  logic [NUMW-1:0]      remu_r, remv_r, dshu_r, dshv_r;
  logic [SW-1:0]        su_r, sv_r;
  logic signed [PW-1:0] produ_r, prodv_r;
  uvsr_pkg::coord_t     xu_r, xv_r;

  logic [uvsr_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic                             out_last_r;
  uvsr_pkg::out_flags_t             out_flags_r;

  logic                 in_acc, out_acc, store_ok;
  uvsr_pkg::coord_t     u_in, v_in, xu, xv;
  logic [EW-1:0]        eu, ev;
  logic [NUMW-1:0]      numu, numv;
  logic                 gu, gv;
  logic signed [D2W-1:0] d2u, d2v;
  logic [uvsr_pkg::OUT_TDATA_W-1:0] rdata;
  uvsr_pkg::coord_t     resu, resv;

  function automatic logic [NUMW-1:0] snap_num(input logic [EW-1:0] e);
    logic [NW-1:0] n;
    n = NW'(e >> FRAC_BITS);
    if (e[FRAC_BITS-1] && (|e[FRAC_BITS-2:0])) begin
      n = n + NW'(1);
    end
    return (NUMW'(n) << (2 * FRAC_BITS)) + NUMW'(e >> 1);
  endfunction

  function automatic uvsr_pkg::coord_t rescale(input logic signed [EW-1:0] c2,
                                               input logic signed [PW-1:0] prod);
    logic signed [ACCW-1:0] acc;
    logic signed [ACCW-1:0] r;
    acc = (ACCW'(c2) <<< FRAC_BITS) + ACCW'(prod) + (ACCW'(1) <<< FRAC_BITS);
    r   = acc >>> (FRAC_BITS + 1);
    if (r > SAT_HI) begin
      return SAT_HI[XW-1:0];
    end else if (r < SAT_LO) begin
      return SAT_LO[XW-1:0];
    end
    return r[XW-1:0];
  endfunction

  assign in_tready  = (state_r == S_LOAD);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = (state_r == S_OUT);
  assign out_acc    = out_tvalid && out_tready;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_flags_r;

  assign u_in     = in_tdata[XW-1:0];
  assign v_in     = in_tdata[2*XW-1:XW];
  assign store_ok = (cnt_r < CW'(MAX_PAIRS));

  uvsr_ram #(
    .WIDTH (uvsr_pkg::OUT_TDATA_W),
    .DEPTH (MAX_PAIRS),
    .ADDR_W(ADDR_W)
  ) u_store (
    .clk  (clk),
    .we   (in_acc && store_ok),
    .waddr(cnt_r[ADDR_W-1:0]),
    .wdata(in_tdata),
    .raddr(k_r[ADDR_W-1:0]),
    .rdata(rdata)
  );

  assign eu   = EW'({umax_r[XW-1], umax_r} - {umin_r[XW-1], umin_r});
  assign ev   = EW'({vmax_r[XW-1], vmax_r} - {vmin_r[XW-1], vmin_r});
  assign numu = snap_num(eu);
  assign numv = snap_num(ev);
  assign gu   = (remu_r >= dshu_r);
  assign gv   = (remv_r >= dshv_r);

  assign xu  = rdata[XW-1:0];
  assign xv  = rdata[2*XW-1:XW];
  assign d2u = (D2W'(xu) <<< 1) - D2W'(c2u_r);
  assign d2v = (D2W'(xv) <<< 1) - D2W'(c2v_r);

  assign resu = flat_u_r ? xu_r : rescale(c2u_r, produ_r);
  assign resv = flat_v_r ? xv_r : rescale(c2v_r, prodv_r);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    drop_nxt  = drop_r;
    umin_nxt  = umin_r;
    umax_nxt  = umax_r;
    vmin_nxt  = vmin_r;
    vmax_nxt  = vmax_r;
    step_nxt  = step_r;
    unique case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (store_ok) begin
            cnt_nxt = cnt_r + CW'(1);
            if (cnt_r == '0) begin
              umin_nxt = u_in;
              umax_nxt = u_in;
              vmin_nxt = v_in;
              vmax_nxt = v_in;
            end else begin
              if (u_in < umin_r) umin_nxt = u_in;
              if (u_in > umax_r) umax_nxt = u_in;
              if (v_in < vmin_r) vmin_nxt = v_in;
              if (v_in > vmax_r) vmax_nxt = v_in;
            end
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_tlast) begin
            state_nxt = S_PREP;
          end
        end
      end
      S_PREP: begin
        step_nxt  = STW'(SW);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        step_nxt = step_r - STW'(1);
        if (step_r == STW'(1)) begin
          k_nxt     = '0;
          state_nxt = S_RD;
        end
      end
      S_RD:  state_nxt = S_MUL;
      S_MUL: state_nxt = S_FIN;
      S_FIN: state_nxt = S_OUT;
      S_OUT: begin
        if (out_acc) begin
          if (out_last_r) begin
            cnt_nxt   = '0;
            drop_nxt  = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_r + CW'(1);
            state_nxt = S_RD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      k_r     <= '0;
      drop_r  <= 1'b0;
      umin_r  <= '0;
      umax_r  <= '0;
      vmin_r  <= '0;
      vmax_r  <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      k_r     <= k_nxt;
      drop_r  <= drop_nxt;
      umin_r  <= umin_nxt;
      umax_r  <= umax_nxt;
      vmin_r  <= vmin_nxt;
      vmax_r  <= vmax_nxt;
      step_r  <= step_nxt;
    end
  end

  // datapath: divider, multiplier and output registers
  always_ff @(posedge clk) begin
    if (state_r == S_PREP) begin
      flat_u_r <= (eu == '0);
      flat_v_r <= (ev == '0);
      c2u_r    <= EW'(umin_r) + EW'(umax_r);
      c2v_r    <= EW'(vmin_r) + EW'(vmax_r);
      remu_r   <= numu;
      remv_r   <= numv;
      dshu_r   <= NUMW'(eu) << (SW - 1);
      dshv_r   <= NUMW'(ev) << (SW - 1);
    end
    if (state_r == S_DIV) begin
      remu_r <= gu ? remu_r - dshu_r : remu_r;
      remv_r <= gv ? remv_r - dshv_r : remv_r;
      dshu_r <= dshu_r >> 1;
      dshv_r <= dshv_r >> 1;
      su_r   <= {su_r[SW-2:0], gu};
      sv_r   <= {sv_r[SW-2:0], gv};
    end
    if (state_r == S_MUL) begin
      xu_r    <= xu;
      xv_r    <= xv;
      produ_r <= d2u * $signed({1'b0, su_r});
      prodv_r <= d2v * $signed({1'b0, sv_r});
    end
    if (state_r == S_FIN) begin
      out_data_r             <= {resv, resu};
      out_last_r             <= (k_r + CW'(1) == cnt_r);
      out_flags_r.flat_u     <= flat_u_r;
      out_flags_r.flat_v     <= flat_v_r;
      out_flags_r.overflowed <= drop_r;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input and output handshakes enabled together");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_PAIRS))
    else $error("pair count beyond store depth");

  a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |-> (k_r < cnt_r))
    else $error("emit index beyond stored pairs");

  a_set_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_tlast) |=> (cnt_r == '0 && !drop_r && in_tready))
    else $error("set not cleared after final result");

  a_div_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && step_r == STW'(1)) |=> (state_r == S_RD && k_r == '0))
    else $error("emit did not start at first entry");

endmodule

### hdl/uvsr_ram.sv
`timescale 1ns / 1ps
// uvsr_ram: generic single-port-write, single-port-read RAM, registered read.
// No dependencies.
module uvsr_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for uv_extent_snap_rescale_unit. A directed table, then random sets of (u, v)
// pairs, each result checked against an in-bench snap/rescale predictor or, for typed rows, the table's values.
// Depends on uvsr_pkg and the unit's RTL.
module testbench;

  localparam int MAX_PAIRS = 64;
  localparam int FRAC_BITS = 16;
  localparam int ITEM_TARGET = 320;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam longint ONE = 64'sd1 << FRAC_BITS;
  localparam longint SAT_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam longint SAT_LO = -64'sh0000_0000_8000_0000;

  typedef struct packed {
    uvsr_pkg::coord_t     u;
    uvsr_pkg::coord_t     v;
    logic                 last;
    uvsr_pkg::out_flags_t flags;
  } rescaled_pair_t;

  typedef struct packed {
    uvsr_pkg::coord_t     u;
    uvsr_pkg::coord_t     v;
    logic                 last;
    logic                 typed;
    uvsr_pkg::coord_t     exp_u;
    uvsr_pkg::coord_t     exp_v;
    uvsr_pkg::out_flags_t exp_flags;
  } stim_row_t;

  logic                             clk;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [uvsr_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                             in_tlast;
  logic                             out_tvalid;
  logic                             out_tready;
  logic [uvsr_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             out_tlast;
  logic [uvsr_pkg::OUT_TUSER_W-1:0] out_tuser;

  uv_extent_snap_rescale_unit #(
    .MAX_PAIRS(MAX_PAIRS),
    .FRAC_BITS(FRAC_BITS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  // predictor state
  uvsr_pkg::coord_t u_buf [MAX_PAIRS];
  uvsr_pkg::coord_t v_buf [MAX_PAIRS];
  uvsr_pkg::coord_t u_lo, u_hi, v_lo, v_hi;
  int               held_pairs;
  bit               pairs_dropped;
  rescaled_pair_t   pending_rescaled [$];

  int send_idle_pct;
  int recv_idle_pct;
  int items_sent;
  int mismatches;
  int cycle_count;

  stim_row_t directed_rows [17] = '{
    '{32'sh7FFFFFFF, 32'sh80000000, 1'b1, 1'b1, 32'sh7FFFFFFF, 32'sh80000000, 3'b011},
    '{32'sh00000000, 32'sh00000000, 1'b1, 1'b1, 32'sh00000000, 32'sh00000000, 3'b011},
    '{32'shFFFFFFFF, 32'sh00000001, 1'b1, 1'b1, 32'shFFFFFFFF, 32'sh00000001, 3'b011},
    // u extent exactly half a unit, v just above
    '{32'sh00000000, 32'sh00000000, 1'b0, 1'b0, 32'sh0, 32'sh0, 3'b000},
    '{32'sh00008000, 32'sh00008001, 1'b1, 1'b0, 32'sh0, 32'sh0, 3'b000},
    // 1.5 units rounds down, 1.5 + ulp rounds up
    '{32'sh00000000, 32'sh00000000, 1'b0, 1'b0, 32'sh0, 32'sh0, 3'b000},
    '{32'sh00018000, 32'sh00018001, 1'b1, 1'b0, 32'sh0, 32'sh0, 3'b000},
    // full signed range on both axes
    '{32'sh80000000, 32'sh7FFFFFFF, 1'b0, 1'b0, 32'sh0, 32'sh0, 3'b000},
    '{32'sh7FFFFFFF, 32'sh80000000, 1'b0, 1'b0, 32'sh0, 32'sh0, 3'b000},
    '{32'sh00000000, 32'sh00000000, 1'b1, 1'b0, 32'sh0, 32'sh0, 3'b000},
    // flat u, spread v
    '{32'sh12345678, 32'sh00000100, 1'b0, 1'b0, 32'sh0, 32'sh0, 3'b000},
    '{32'sh12345678, 32'shFFFD0000, 1'b0, 1'b0, 32'sh0, 32'sh0, 3'b000},
    '{32'sh12345678, 32'sh00025000, 1'b1, 1'b0, 32'sh0, 32'sh0, 3'b000},
    '{32'sh00031000, 32'shFFFF0000, 1'b0, 1'b0, 32'sh0, 32'sh0, 3'b000},
    '{32'shFFFE8000, 32'sh00047123, 1'b0, 1'b0, 32'sh0, 32'sh0, 3'b000},
    '{32'sh00010000, 32'sh00000000, 1'b0, 1'b0, 32'sh0, 32'sh0, 3'b000},
    '{32'sh00020000, 32'sh00010000, 1'b1, 1'b0, 32'sh0, 32'sh0, 3'b000}
  };

  function automatic longint snap_scale(input longint ext);
    longint unsigned e, n;
    e = ext;
    n = e >> FRAC_BITS;
    if ((e & (ONE - 1)) > (ONE >> 1)) n = n + 1;
    return ((n << (2 * FRAC_BITS)) + (e >> 1)) / e;
  endfunction

  function automatic uvsr_pkg::coord_t rescale_coord(input uvsr_pkg::coord_t x,
                                                     input longint c2, input longint s);
    longint d2, acc, r;
    d2 = 2 * longint'(x) - c2;
    acc = c2 * ONE + d2 * s + ONE;
    r = acc >>> (FRAC_BITS + 1);
    if (r > SAT_HI) r = SAT_HI;
    if (r < SAT_LO) r = SAT_LO;
    return uvsr_pkg::coord_t'(r);
  endfunction

  task automatic absorb_pair(input uvsr_pkg::coord_t u, input uvsr_pkg::coord_t v,
                             input logic last);
    longint         ue, ve, uc2, vc2, us, vs;
    bit             fu, fv;
    rescaled_pair_t r;
    if (held_pairs < MAX_PAIRS) begin
      if (held_pairs == 0) begin
        u_lo = u; u_hi = u; v_lo = v; v_hi = v;
      end else begin
        if (u < u_lo) u_lo = u;
        if (u > u_hi) u_hi = u;
        if (v < v_lo) v_lo = v;
        if (v > v_hi) v_hi = v;
      end
      u_buf[held_pairs] = u;
      v_buf[held_pairs] = v;
      held_pairs++;
    end else begin
      pairs_dropped = 1'b1;
    end
    if (!last) return;
    ue = longint'(u_hi) - longint'(u_lo);
    ve = longint'(v_hi) - longint'(v_lo);
    fu = (ue == 0);
    fv = (ve == 0);
    us = fu ? 0 : snap_scale(ue);
    vs = fv ? 0 : snap_scale(ve);
    uc2 = longint'(u_lo) + longint'(u_hi);
    vc2 = longint'(v_lo) + longint'(v_hi);
    for (int k = 0; k < held_pairs; k++) begin
      r.u = fu ? u_buf[k] : rescale_coord(u_buf[k], uc2, us);
      r.v = fv ? v_buf[k] : rescale_coord(v_buf[k], vc2, vs);
      r.last = (k == held_pairs - 1);
      r.flags.flat_u = fu;
      r.flags.flat_v = fv;
      r.flags.overflowed = pairs_dropped;
      pending_rescaled.push_back(r);
    end
    held_pairs = 0;
    pairs_dropped = 1'b0;
  endtask

  task automatic send_pair(input uvsr_pkg::coord_t u, input uvsr_pkg::coord_t v,
                           input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {v, u};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    absorb_pair(u, v, last);
  endtask

  function automatic int unsigned pick_span();
    case ($urandom_range(5))
      0: return 0;
      1: return 32'h8000;
      2: return 32'h18000;
      3: return $urandom_range(32'hFFFFF);
      4: return $urandom_range(32'h3FFFFFF);
      default: return 32'hFFFFFFFF;
    endcase
  endfunction

  task automatic send_random_set(input int len);
    uvsr_pkg::coord_t ub, vb;
    int unsigned      uspan, vspan;
    ub = $urandom;
    vb = $urandom;
    uspan = pick_span();
    vspan = pick_span();
    for (int i = 0; i < len; i++)
      send_pair(ub + uvsr_pkg::coord_t'($urandom_range(uspan)),
                vb + uvsr_pkg::coord_t'($urandom_range(vspan)),
                i == len - 1);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    rescaled_pair_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.u = out_tdata[uvsr_pkg::COORD_W-1:0];
      got.v = out_tdata[2*uvsr_pkg::COORD_W-1:uvsr_pkg::COORD_W];
      got.last = out_tlast;
      got.flags = uvsr_pkg::out_flags_t'(out_tuser);
      if (pending_rescaled.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: u=%h v=%h last=%b flags=%b",
                   got.u, got.v, got.last, got.flags);
      end else begin
        want = pending_rescaled.pop_front();
        if (got.u !== want.u || got.v !== want.v || got.last !== want.last ||
            got.flags !== want.flags) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp u=%h v=%h last=%b flags=%b, got u=%h v=%h last=%b flags=%b",
                     want.u, want.v, want.last, want.flags,
                     got.u, got.v, got.last, got.flags);
        end
      end
    end
  end

  initial begin
    int             set_idx;
    int             len;
    rescaled_pair_t typed_pair;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    send_idle_pct = 23;
    recv_idle_pct = 66;
    items_sent = 0;
    held_pairs = 0;
    pairs_dropped = 1'b0;
    u_lo = '0; u_hi = '0; v_lo = '0; v_hi = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_pair(directed_rows[i].u, directed_rows[i].v, directed_rows[i].last);
      if (directed_rows[i].typed) begin
        // single-pair set: result is known by inspection
        void'(pending_rescaled.pop_back());
        typed_pair.u = directed_rows[i].exp_u;
        typed_pair.v = directed_rows[i].exp_v;
        typed_pair.last = 1'b1;
        typed_pair.flags = directed_rows[i].exp_flags;
        pending_rescaled.push_back(typed_pair);
      end
    end

    set_idx = 0;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent < ITEM_TARGET / 3) begin
        send_idle_pct = 23; recv_idle_pct = 66;
      end else if (items_sent < 2 * ITEM_TARGET / 3) begin
        send_idle_pct = 66; recv_idle_pct = 23;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      // full depth, a dropped last pair, and a long overrun
      case (set_idx)
        2: len = MAX_PAIRS;
        5: len = MAX_PAIRS + 1;
        9: len = MAX_PAIRS + 6;
        default: len = ($urandom_range(7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
      endcase
      send_random_set(len);
      set_idx++;
    end
    in_tvalid <= 1'b0;

    while (pending_rescaled.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### files.f
hdl/uvsr_pkg.sv
hdl/uvsr_ram.sv
hdl/uv_extent_snap_rescale_unit.sv
tb/testbench.sv
